// File: hdl/crc_framed_xor_stream_cipher_assert.svh
// assertion macros used by the cipher core
// needs a clock and an active-low reset named at each use
`ifndef CRC_FRAMED_XOR_STREAM_CIPHER_ASSERT_SVH
`define CRC_FRAMED_XOR_STREAM_CIPHER_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define CFXSC_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("cfxsc assertion failed");

// condition in this cycle implies consequence in the next cycle
`define CFXSC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("cfxsc assertion failed");

`endif

// File: hdl/cfxsc_pkg.sv
// shared types, codes, key table and crc byte update for the cipher
// no dependencies
package cfxsc_pkg;

    localparam int KEY_MAX        = 256;
    localparam int KEY_LENGTH_DEF = 32;

    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY_RST = 32'hEDB8_8320;
    localparam logic [31:0] SEED_A       = 32'h9E37_79B9;
    localparam logic [31:0] SEED_B       = 32'h85EB_CA77;
    localparam logic [31:0] SEED_C       = 32'hC2B2_AE3D;
    localparam logic [31:0] SEED_D       = 32'h27D4_EB2F;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY = 2'd1;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // verify status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // one input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } item_t;

    typedef logic [7:0] key_rom_t [KEY_MAX];

    // xorshift and multiply step of the key generator
    function automatic logic [31:0] scramble(input logic [31:0] s_in, input logic [31:0] salt);
        logic [31:0] s;
        s = s_in + salt + SEED_C;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        return 32'(s * SEED_D);
    endfunction

    // full key table, evaluated at elaboration
    function automatic key_rom_t build_key();
        key_rom_t    rom;
        logic [31:0] s;
        s = SEED_A ^ SEED_B ^ SEED_C ^ SEED_D;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            s      = scramble(s, 32'(i));
            rom[i] = s[31:24];
        end
        return rom;
    endfunction

    localparam key_rom_t KEY_ROM = build_key();

    // reflected crc update by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b,
                                             input logic [31:0] poly);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            crc = crc[0] ? ((crc >> 1) ^ poly) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

// File: hdl/cfxsc_in_stage.sv
// input register: holds one item for the core, drives the input stall
// depends on cfxsc_pkg
module cfxsc_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cfxsc_pkg::item_t     in_item,
    output logic                 item_valid,
    output cfxsc_pkg::item_t     item,
    input  logic                 pop
);
    import cfxsc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // held item blocks the port until the core retires it
    assign in_stall   = valid_reg && !pop;
    assign valid_next = in_stall ? 1'b1 : in_valid;

    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: hdl/cfxsc_core.sv
// message state, byte transform, crc and result register
// depends on cfxsc_pkg and the assertion macro header
module cfxsc_core #(
    parameter int KEY_LENGTH = cfxsc_pkg::KEY_LENGTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cfxsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfxsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 item_valid,
    input  cfxsc_pkg::item_t                     item,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [7:0]                           out_byte,
    output logic [1:0]                           byte_kind,
    output logic [1:0]                           header_index,
    output logic [1:0]                           status,
    output logic                                 last_result
);
    import cfxsc_pkg::*;

`include "crc_framed_xor_stream_cipher_assert.svh"

    localparam int KEY_IDX_W = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
    localparam logic [KEY_IDX_W-1:0] KEY_LAST      = KEY_IDX_W'(KEY_LENGTH - 1);
    localparam logic [KEY_IDX_W-1:0] KEY_START_ENC = KEY_IDX_W'(4 % KEY_LENGTH);
    localparam logic [7:0] HDR_KEY0 = KEY_ROM[0 % KEY_LENGTH];
    localparam logic [7:0] HDR_KEY1 = KEY_ROM[1 % KEY_LENGTH];
    localparam logic [7:0] HDR_KEY2 = KEY_ROM[2 % KEY_LENGTH];
    localparam logic [7:0] HDR_KEY3 = KEY_ROM[3 % KEY_LENGTH];

    logic                 mode_reg, mode_next;
    logic [31:0]          poly_reg, poly_next;
    logic [7:0]           frame_pos_reg, frame_pos_next;
    logic [KEY_IDX_W-1:0] key_pos_reg, key_pos_next;
    logic [2:0]           hdr_count_reg, hdr_count_next;
    logic [31:0]          crc_reg, crc_next;
    logic [31:0]          stored_reg, stored_next;
    logic                 byte_done_reg, byte_done_next;
    logic [1:0]           end_idx_reg, end_idx_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic [1:0]           kind_reg, kind_next;
    logic [1:0]           hidx_reg, hidx_next;
    logic [1:0]           status_reg, status_next;
    logic                 last_reg, last_next;

    logic                 out_free;
    logic                 adv;
    logic                 do_byte;
    logic                 restart;
    logic                 restart_mode;
    logic [7:0]           rom_addr;
    logic [7:0]           xbyte;
    logic [31:0]          crc_final;
    logic [7:0]           crc_lane;
    logic [7:0]           hdr_key;
    logic [7:0]           crc_in_byte;

    assign out_free    = !out_valid_reg || !out_stall;
    assign adv         = item_valid && out_free;
    assign do_byte     = item.byte_valid && !byte_done_reg;
    assign rom_addr    = 8'(key_pos_reg);
    assign xbyte       = item.data_byte ^ KEY_ROM[rom_addr] ^ frame_pos_reg;
    assign crc_final   = crc_reg ^ CRC_ALL_ONES;
    assign crc_lane    = crc_final[{end_idx_reg, 3'b000} +: 8];
    assign crc_in_byte = mode_reg ? item.data_byte : xbyte;

    // key byte for each header position
    always_comb
    begin
        case (end_idx_reg)
            2'd0:    hdr_key = HDR_KEY0;
            2'd1:    hdr_key = HDR_KEY1;
            2'd2:    hdr_key = HDR_KEY2;
            2'd3:    hdr_key = HDR_KEY3;
            default: hdr_key = HDR_KEY0;
        endcase
    end

    // item processing: one byte, one header byte or one status per cycle while the output is free
    always_comb
    begin
        mode_next      = mode_reg;
        poly_next      = poly_reg;
        frame_pos_next = frame_pos_reg;
        key_pos_next   = key_pos_reg;
        hdr_count_next = hdr_count_reg;
        crc_next       = crc_reg;
        stored_next    = stored_reg;
        byte_done_next = byte_done_reg;
        end_idx_next   = end_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        kind_next      = kind_reg;
        hidx_next      = hidx_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        restart        = 1'b0;
        restart_mode   = mode_reg;

        if (adv && do_byte)
        begin
            // data byte
            if (mode_reg || hdr_count_reg[2])
            begin
                crc_next       = crc_byte(crc_reg, crc_in_byte, poly_reg);
                out_valid_next = 1'b1;
                out_byte_next  = xbyte;
                kind_next      = KIND_PAYLOAD;
                hidx_next      = 2'd0;
                status_next    = ST_OK;
                last_next      = 1'b0;
            end
            else
            begin
                stored_next[{hdr_count_reg[1:0], 3'b000} +: 8] = xbyte;
                hdr_count_next = hdr_count_reg + 3'd1;
            end
            frame_pos_next = frame_pos_reg + 8'd1;
            key_pos_next   = (key_pos_reg == KEY_LAST) ? '0 : key_pos_reg + KEY_IDX_W'(1);
            if (item.message_end)
            begin
                byte_done_next = 1'b1;
            end
            else
            begin
                pop = 1'b1;
            end
        end
        else if (adv && item.message_end)
        begin
            out_valid_next = 1'b1;
            hidx_next      = 2'd0;
            status_next    = ST_OK;
            out_byte_next  = 8'd0;
            if (mode_reg)
            begin
                // encrypted checksum bytes, positions 0 to 3
                out_byte_next = crc_lane ^ hdr_key ^ {6'd0, end_idx_reg};
                kind_next     = KIND_HEADER;
                hidx_next     = end_idx_reg;
                last_next     = (end_idx_reg == 2'd3);
                end_idx_next  = end_idx_reg + 2'd1;
                if (end_idx_reg == 2'd3)
                begin
                    pop     = 1'b1;
                    restart = 1'b1;
                end
            end
            else
            begin
                // verify status
                kind_next = KIND_STATUS;
                last_next = 1'b1;
                if (!hdr_count_reg[2])
                begin
                    status_next = ST_SHORT;
                end
                else if (crc_final != stored_reg)
                begin
                    status_next = ST_MISMATCH;
                end
                pop     = 1'b1;
                restart = 1'b1;
            end
        end
        else if (adv)
        begin
            // empty item
            pop = 1'b1;
        end

        if (pop)
        begin
            byte_done_next = 1'b0;
            end_idx_next   = 2'd0;
        end

        // configuration writes
        if (cfg_we && cfg_index == REG_MODE)
        begin
            mode_next    = cfg_data[0];
            restart      = 1'b1;
            restart_mode = cfg_data[0];
        end
        if (cfg_we && cfg_index == REG_CRC_POLY)
        begin
            poly_next = cfg_data;
        end

        // message state back to its start values
        if (restart)
        begin
            frame_pos_next = restart_mode ? 8'd4 : 8'd0;
            key_pos_next   = restart_mode ? KEY_START_ENC : '0;
            hdr_count_next = 3'd0;
            crc_next       = CRC_ALL_ONES;
            stored_next    = 32'd0;
        end
    end

    // control and message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            poly_reg      <= CRC_POLY_RST;
            frame_pos_reg <= 8'd0;
            key_pos_reg   <= '0;
            hdr_count_reg <= 3'd0;
            crc_reg       <= CRC_ALL_ONES;
            stored_reg    <= 32'd0;
            byte_done_reg <= 1'b0;
            end_idx_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            poly_reg      <= poly_next;
            frame_pos_reg <= frame_pos_next;
            key_pos_reg   <= key_pos_next;
            hdr_count_reg <= hdr_count_next;
            crc_reg       <= crc_next;
            stored_reg    <= stored_next;
            byte_done_reg <= byte_done_next;
            end_idx_reg   <= end_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        kind_reg     <= kind_next;
        hidx_reg     <= hidx_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_kind    = kind_reg;
    assign header_index = hidx_reg;
    assign status       = status_reg;
    assign last_result  = last_reg;

    // checks
    `CFXSC_ASSERT_NOW(a_enc_no_header_count, clk, rst_n, mode_reg, hdr_count_reg == 3'd0)
    `CFXSC_ASSERT_NOW(a_last_header_idx, clk, rst_n, out_valid_reg && last_reg && kind_reg == KIND_HEADER, hidx_reg == 2'd3)
    `CFXSC_ASSERT_NOW(a_status_only_kind, clk, rst_n, out_valid_reg && kind_reg != KIND_STATUS, status_reg == ST_OK)
    `CFXSC_ASSERT_NEXT(a_end_restarts, clk, rst_n, pop && item.message_end && !cfg_we, crc_reg == CRC_ALL_ONES && hdr_count_reg == 3'd0)

endmodule

// File: hdl/crc_framed_xor_stream_cipher.sv
// top level of the crc framed xor stream cipher
// depends on cfxsc_pkg, cfxsc_in_stage and cfxsc_core
//
//   port group   handshake              payload
//   input        in_valid / in_stall    data_byte, byte_valid, message_end
//   output       out_valid / out_stall  out_byte, byte_kind, header_index, status, last_result
//   config       cfg_we                 cfg_index, cfg_data
//
// one item per cycle through an input register and a result register while out_stall is low
// an encrypt message end gives one result per checksum byte; a byte with
// an end mark gives its byte result before its end results
// reset is asynchronous; results are held while out_stall is high and the
// input stalls while the input register holds an item the core does not retire
module crc_framed_xor_stream_cipher #(
    parameter int KEY_LENGTH = cfxsc_pkg::KEY_LENGTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cfxsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfxsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              byte_valid,
    input  logic                              message_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_byte,
    output logic [1:0]                        byte_kind,
    output logic [1:0]                        header_index,
    output logic [1:0]                        status,
    output logic                              last_result
);
    import cfxsc_pkg::*;

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  pop;

    assign in_item.data_byte   = data_byte;
    assign in_item.byte_valid  = byte_valid;
    assign in_item.message_end = message_end;

    // input register
    cfxsc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    // transform, crc and results
    cfxsc_core #(
        .KEY_LENGTH (KEY_LENGTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item         (item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_kind    (byte_kind),
        .header_index (header_index),
        .status       (status),
        .last_result  (last_result)
    );

endmodule
